// ----- rtl/cssd_pkg.sv -----
// ----------------------------------------------------------------------------
// cssd_pkg
// Types, constants and 8b10b code functions shared by the decoder modules.
// ----------------------------------------------------------------------------
package cssd_pkg;

    localparam int unsigned WORD_W  = 10;
    localparam int unsigned BYTE_W  = 8;
    localparam int unsigned DIST_W  = 4;
    localparam int unsigned CFG_IDX_W = 1;
    localparam int unsigned CFG_DATA_W = 10;

    localparam logic [CFG_IDX_W-1:0] REG_COMMA = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_FRAME = 1'd1;

    localparam logic [WORD_W-1:0] COMMA_RESET = 10'd250;
    localparam logic [BYTE_W-1:0] FRAME_RESET = 8'd255;

    localparam logic KIND_COMMA = 1'b0;
    localparam logic KIND_BYTE  = 1'b1;

    localparam logic [DIST_W-1:0] NO_DIST = 4'd11;
    localparam logic [3:0] LAST_PHASE = 4'd9;

    localparam logic [5:0] SIX_MINUS [32] = '{
        6'h27, 6'h1D, 6'h2D, 6'h31, 6'h35, 6'h29, 6'h19, 6'h38,
        6'h39, 6'h25, 6'h15, 6'h34, 6'h0D, 6'h2C, 6'h1C, 6'h17,
        6'h1B, 6'h23, 6'h13, 6'h32, 6'h0B, 6'h2A, 6'h1A, 6'h3A,
        6'h33, 6'h26, 6'h16, 6'h36, 6'h0E, 6'h2E, 6'h1E, 6'h2B
    };

    localparam logic [3:0] FOUR_MINUS [8] = '{
        4'hB, 4'h9, 4'h5, 4'hC, 4'hD, 4'hA, 4'h6, 4'hE
    };

    typedef struct packed {
        logic              kind;
        logic [WORD_W-1:0] word;
        logic [BYTE_W-1:0] idx;
        logic              last;
    } entry_t;

    function automatic logic [DIST_W-1:0] ones10(input logic [WORD_W-1:0] v);
        logic [DIST_W-1:0] n;
        n = '0;
        for (int i = 0; i < WORD_W; i++)
        begin
            n = n + {3'd0, v[i]};
        end
        return n;
    endfunction

    function automatic logic [WORD_W-1:0] code_word(input logic [BYTE_W-1:0] b,
                                                    input logic rd_plus);
        logic [4:0] x;
        logic [2:0] y;
        logic [5:0] six;
        logic [3:0] four;
        logic       unbal;
        logic       rd;
        logic       alt;
        x     = b[4:0];
        y     = b[7:5];
        six   = SIX_MINUS[x];
        unbal = ones10({4'd0, six}) != 4'd3;
        rd    = rd_plus;
        if (rd && (unbal || x == 5'd7))
        begin
            six = ~six;
        end
        if (unbal)
        begin
            rd = ~rd;
        end
        if (y == 3'd7)
        begin
            alt = (!rd && (x == 5'd17 || x == 5'd18 || x == 5'd20)) ||
                  (rd && (x == 5'd11 || x == 5'd13 || x == 5'd14));
            four = alt ? 4'h7 : 4'hE;
            if (rd)
            begin
                four = ~four;
            end
        end
        else
        begin
            four = FOUR_MINUS[y];
            if (rd && (ones10({6'd0, four}) != 4'd2 || y == 3'd3))
            begin
                four = ~four;
            end
        end
        return {six, four};
    endfunction

endpackage

// ----- rtl/cssd_if.sv -----
// ----------------------------------------------------------------------------
// cssd interfaces
// Bit input, result output and configuration write channels.
// ----------------------------------------------------------------------------
interface cssd_bit_if;
    logic valid;
    logic ready;
    logic in_bit;
    modport source (output valid, output in_bit, input ready);
    modport sink (input valid, input in_bit, output ready);
endinterface

interface cssd_evt_if;
    logic                       valid;
    logic                       ready;
    logic                       event_kind;
    logic [cssd_pkg::BYTE_W-1:0] data_byte;
    logic                       erased;
    logic [cssd_pkg::DIST_W-1:0] distance;
    logic [cssd_pkg::BYTE_W-1:0] byte_index;
    logic [cssd_pkg::BYTE_W-1:0] erasure_count;
    logic                       last_of_frame;
    modport source (output valid, output event_kind, output data_byte, output erased,
                    output distance, output byte_index, output erasure_count,
                    output last_of_frame, input ready);
    modport sink (input valid, input event_kind, input data_byte, input erased,
                  input distance, input byte_index, input erasure_count,
                  input last_of_frame, output ready);
endinterface

interface cssd_cfg_if;
    logic                            valid;
    logic                            ready;
    logic [cssd_pkg::CFG_IDX_W-1:0]  index;
    logic [cssd_pkg::CFG_DATA_W-1:0] data;
    modport source (output valid, output index, output data, input ready);
    modport sink (input valid, input index, input data, output ready);
endinterface

// ----- rtl/cssd_front.sv -----
// ----------------------------------------------------------------------------
// cssd_front
// Comma hunt, word framing and frame counting; pushes transactions to queue.
// ----------------------------------------------------------------------------
module cssd_front #(
    parameter int unsigned MAX_FRAME = 255
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          bit_valid,
    input  logic                          bit_val,
    input  logic                          q_full,
    output logic                          bit_ready,
    input  logic [cssd_pkg::WORD_W-1:0]   comma,
    input  logic [cssd_pkg::BYTE_W-1:0]   frame_len,
    output logic                          push,
    output cssd_pkg::entry_t              push_entry
);

    localparam logic [cssd_pkg::BYTE_W-1:0] MAXF = cssd_pkg::BYTE_W'(MAX_FRAME);

    logic [cssd_pkg::WORD_W-1:0] hunt_reg, hunt_next;
    logic [cssd_pkg::WORD_W-1:0] word_reg, word_next;
    logic                        dec_reg, dec_next;
    logic [3:0]                  phase_reg, phase_next;
    logic [cssd_pkg::BYTE_W-1:0] count_reg, count_next;
    logic [cssd_pkg::BYTE_W-1:0] fw;
    logic [cssd_pkg::BYTE_W:0]   count_inc;
    logic                        acc;
    logic                        last;

    assign bit_ready = !q_full;
    assign acc       = bit_valid && bit_ready;
    assign count_inc = {1'b0, count_reg} + 9'd1;

    always_comb
    begin
        fw = frame_len;
        if (fw == '0)
        begin
            fw = 8'd1;
        end
        if (fw > MAXF)
        begin
            fw = MAXF;
        end
    end

    assign last = count_inc >= {1'b0, fw};

    always_comb
    begin
        hunt_next  = hunt_reg;
        word_next  = word_reg;
        dec_next   = dec_reg;
        phase_next = phase_reg;
        count_next = count_reg;
        push       = 1'b0;
        push_entry = '{kind: cssd_pkg::KIND_COMMA, word: word_reg, idx: count_reg, last: 1'b0};
        if (acc)
        begin
            if (!dec_reg)
            begin
                hunt_next = {hunt_reg[cssd_pkg::WORD_W-2:0], bit_val};
                if (hunt_next == comma || hunt_next == ~comma)
                begin
                    dec_next   = 1'b1;
                    phase_next = '0;
                    word_next  = '0;
                    count_next = '0;
                    push       = 1'b1;
                    push_entry = '{kind: cssd_pkg::KIND_COMMA, word: '0, idx: '0, last: 1'b0};
                end
            end
            else
            begin
                word_next = {word_reg[cssd_pkg::WORD_W-2:0], bit_val};
                if (phase_reg < cssd_pkg::LAST_PHASE)
                begin
                    phase_next = phase_reg + 4'd1;
                end
                else
                begin
                    phase_next = '0;
                    push       = 1'b1;
                    push_entry = '{kind: cssd_pkg::KIND_BYTE, word: word_next,
                                   idx: count_reg, last: last};
                    if (last)
                    begin
                        dec_next   = 1'b0;
                        count_next = '0;
                    end
                    else
                    begin
                        count_next = count_inc[cssd_pkg::BYTE_W-1:0];
                    end
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hunt_reg  <= '0;
            word_reg  <= '0;
            dec_reg   <= 1'b0;
            phase_reg <= '0;
            count_reg <= '0;
        end
        else
        begin
            hunt_reg  <= hunt_next;
            word_reg  <= word_next;
            dec_reg   <= dec_next;
            phase_reg <= phase_next;
            count_reg <= count_next;
        end
    end

endmodule

// ----- rtl/cssd_queue.sv -----
// ----------------------------------------------------------------------------
// cssd_queue
// Two-entry FIFO between the framing front and the search back.
// ----------------------------------------------------------------------------
module cssd_queue (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  cssd_pkg::entry_t push_entry,
    output logic             full,
    input  logic             pop,
    output logic             not_empty,
    output cssd_pkg::entry_t head
);

    cssd_pkg::entry_t mem_reg [2];
    logic       wr_reg, wr_next;
    logic       rd_reg, rd_next;
    logic [1:0] cnt_reg, cnt_next;

    assign full      = cnt_reg == 2'd2;
    assign not_empty = cnt_reg != 2'd0;
    assign head      = mem_reg[rd_reg];

    always_comb
    begin
        wr_next  = push ? ~wr_reg : wr_reg;
        rd_next  = pop ? ~rd_reg : rd_reg;
        cnt_next = cnt_reg + {1'b0, push} - {1'b0, pop};
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_reg] <= push_entry;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_reg  <= 1'b0;
            rd_reg  <= 1'b0;
            cnt_reg <= '0;
        end
        else
        begin
            wr_reg  <= wr_next;
            rd_reg  <= rd_next;
            cnt_reg <= cnt_next;
        end
    end

endmodule

// ----- rtl/cssd_back.sv -----
// ----------------------------------------------------------------------------
// cssd_back
// Nearest code word search, one candidate per cycle, and result register.
// ----------------------------------------------------------------------------
module cssd_back (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             q_valid,
    input  cssd_pkg::entry_t q_head,
    output logic             pop,
    cssd_evt_if.source       evt
);

    localparam logic [1:0] ST_IDLE   = 2'd0;
    localparam logic [1:0] ST_SEARCH = 2'd1;
    localparam logic [1:0] ST_DONE   = 2'd2;

    logic [1:0]                  st_reg, st_next;
    cssd_pkg::entry_t            ent_reg, ent_next;
    logic [8:0]                  cand_reg, cand_next;
    logic [cssd_pkg::BYTE_W-1:0] best_reg, best_next;
    logic [cssd_pkg::DIST_W-1:0] bestd_reg, bestd_next;
    logic [cssd_pkg::BYTE_W-1:0] er_reg, er_next;
    logic                        ov_reg, ov_next;
    logic                        ok_reg, ok_next;
    logic [cssd_pkg::BYTE_W-1:0] ob_reg, ob_next;
    logic                        oe_reg, oe_next;
    logic [cssd_pkg::DIST_W-1:0] od_reg, od_next;
    logic [cssd_pkg::BYTE_W-1:0] oi_reg, oi_next;
    logic [cssd_pkg::BYTE_W-1:0] oc_reg, oc_next;
    logic                        ol_reg, ol_next;
    logic [cssd_pkg::DIST_W-1:0] d;
    logic                        slot_free;

    assign d = cssd_pkg::ones10(ent_reg.word ^ cssd_pkg::code_word(cand_reg[7:0], cand_reg[8]));
    assign slot_free = !ov_reg || evt.ready;
    assign pop = (st_reg == ST_IDLE) && q_valid;

    always_comb
    begin
        st_next    = st_reg;
        ent_next   = ent_reg;
        cand_next  = cand_reg;
        best_next  = best_reg;
        bestd_next = bestd_reg;
        er_next    = er_reg;
        ov_next    = ov_reg && !evt.ready;
        ok_next    = ok_reg;
        ob_next    = ob_reg;
        oe_next    = oe_reg;
        od_next    = od_reg;
        oi_next    = oi_reg;
        oc_next    = oc_reg;
        ol_next    = ol_reg;
        unique case (st_reg)
            ST_IDLE:
            begin
                if (q_valid)
                begin
                    ent_next   = q_head;
                    cand_next  = '0;
                    best_next  = '0;
                    bestd_next = cssd_pkg::NO_DIST;
                    st_next    = (q_head.kind == cssd_pkg::KIND_BYTE) ? ST_SEARCH : ST_DONE;
                end
            end
            ST_SEARCH:
            begin
                if (d < bestd_reg)
                begin
                    bestd_next = d;
                    best_next  = cand_reg[7:0];
                end
                cand_next = cand_reg + 9'd1;
                if (d == '0 || cand_reg == 9'h1FF)
                begin
                    st_next = ST_DONE;
                end
            end
            ST_DONE:
            begin
                if (slot_free)
                begin
                    ov_next = 1'b1;
                    st_next = ST_IDLE;
                    if (ent_reg.kind == cssd_pkg::KIND_COMMA)
                    begin
                        er_next = '0;
                        ok_next = cssd_pkg::KIND_COMMA;
                        ob_next = '0;
                        oe_next = 1'b0;
                        od_next = '0;
                        oi_next = '0;
                        oc_next = '0;
                        ol_next = 1'b0;
                    end
                    else
                    begin
                        if (bestd_reg != '0 && er_reg != 8'hFF)
                        begin
                            er_next = er_reg + 8'd1;
                        end
                        ok_next = cssd_pkg::KIND_BYTE;
                        ob_next = best_reg;
                        oe_next = bestd_reg != '0;
                        od_next = bestd_reg;
                        oi_next = ent_reg.idx;
                        oc_next = er_next;
                        ol_next = ent_reg.last;
                    end
                end
            end
            default:
            begin
                st_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        ent_reg   <= ent_next;
        cand_reg  <= cand_next;
        best_reg  <= best_next;
        bestd_reg <= bestd_next;
        ok_reg    <= ok_next;
        ob_reg    <= ob_next;
        oe_reg    <= oe_next;
        od_reg    <= od_next;
        oi_reg    <= oi_next;
        oc_reg    <= oc_next;
        ol_reg    <= ol_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg <= ST_IDLE;
            er_reg <= '0;
            ov_reg <= 1'b0;
        end
        else
        begin
            st_reg <= st_next;
            er_reg <= er_next;
            ov_reg <= ov_next;
        end
    end

    assign evt.valid         = ov_reg;
    assign evt.event_kind    = ok_reg;
    assign evt.data_byte     = ob_reg;
    assign evt.erased        = oe_reg;
    assign evt.distance      = od_reg;
    assign evt.byte_index    = oi_reg;
    assign evt.erasure_count = oc_reg;
    assign evt.last_of_frame = ol_reg;

endmodule

// ----- rtl/comma_sync_soft_8b10b_decoder_core.sv -----
// ----------------------------------------------------------------------------
// comma_sync_soft_8b10b_decoder_core
// 8b10b receiver with comma hunt and nearest code word decoding.
// ----------------------------------------------------------------------------
// bits:   one received bit per transaction, oldest first.
// cfg:    register writes (0 = comma pattern, 1 = frame length), ready always
//         high; write only while the block is idle.
// events: one transaction per comma found or per decoded 10-bit word.
// The front hunts for the comma and frames words; a two-entry queue feeds the
// back, which scans the 512 RD-/RD+ code words one per cycle and stops at the
// first exact match, then loads the result register; a comma event goes straight
// to the result register without a scan. Bits are taken one per cycle while the
// queue has room.
// Reset clears all framing state and restores the register defaults.
// When the event receiver stalls, the result register holds, the back waits,
// the queue fills and bits stop being accepted.
// ----------------------------------------------------------------------------
module comma_sync_soft_8b10b_decoder_core #(
    parameter int unsigned MAX_FRAME = 255
) (
    input  logic         clk,
    input  logic         rst_n,
    cssd_cfg_if.sink     cfg,
    cssd_bit_if.sink     bits,
    cssd_evt_if.source   events
);

    logic [cssd_pkg::WORD_W-1:0] comma_reg;
    logic [cssd_pkg::BYTE_W-1:0] frame_reg;
    logic                        q_full;
    logic                        q_valid;
    logic                        push;
    logic                        pop;
    cssd_pkg::entry_t            push_entry;
    cssd_pkg::entry_t            head;

    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            comma_reg <= cssd_pkg::COMMA_RESET;
            frame_reg <= cssd_pkg::FRAME_RESET;
        end
        else if (cfg.valid)
        begin
            unique case (cfg.index)
                cssd_pkg::REG_COMMA: comma_reg <= cfg.data;
                cssd_pkg::REG_FRAME: frame_reg <= cfg.data[cssd_pkg::BYTE_W-1:0];
                default: ;
            endcase
        end
    end

    cssd_front #(.MAX_FRAME(MAX_FRAME)) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .bit_valid  (bits.valid),
        .bit_val    (bits.in_bit),
        .q_full     (q_full),
        .bit_ready  (bits.ready),
        .comma      (comma_reg),
        .frame_len  (frame_reg),
        .push       (push),
        .push_entry (push_entry)
    );

    cssd_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_entry (push_entry),
        .full       (q_full),
        .pop        (pop),
        .not_empty  (q_valid),
        .head       (head)
    );

    cssd_back u_back (
        .clk     (clk),
        .rst_n   (rst_n),
        .q_valid (q_valid),
        .q_head  (head),
        .pop     (pop),
        .evt     (events)
    );

endmodule

// ----- rtl/cssd_checker.sv -----
// ----------------------------------------------------------------------------
// cssd_checker
// Port-level assertions on the decoder result channel.
// ----------------------------------------------------------------------------
module cssd_checker (
    input logic                          clk,
    input logic                          rst_n,
    input logic                          ev_valid,
    input logic                          ev_ready,
    input logic                          ev_kind,
    input logic [cssd_pkg::BYTE_W-1:0]   ev_byte,
    input logic                          ev_erased,
    input logic [cssd_pkg::DIST_W-1:0]   ev_dist,
    input logic [cssd_pkg::BYTE_W-1:0]   ev_idx,
    input logic [cssd_pkg::BYTE_W-1:0]   ev_count,
    input logic                          ev_last
);

    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        ev_valid && !ev_ready |=> ev_valid && $stable(ev_byte) && $stable(ev_dist))
        else $error("result dropped while stalled");

    a_comma_zero: assert property (@(posedge clk) disable iff (!rst_n)
        ev_valid && ev_kind == cssd_pkg::KIND_COMMA |->
        ev_byte == '0 && ev_dist == '0 && ev_idx == '0 && ev_count == '0 && !ev_last
        && !ev_erased)
        else $error("comma transaction with nonzero fields");

    a_erased: assert property (@(posedge clk) disable iff (!rst_n)
        ev_valid && ev_kind == cssd_pkg::KIND_BYTE |->
        ev_erased == (ev_dist != '0) && ev_dist <= 4'd10)
        else $error("erasure flag and distance disagree");

    a_count: assert property (@(posedge clk) disable iff (!rst_n)
        ev_valid && ev_kind == cssd_pkg::KIND_BYTE && ev_erased |-> ev_count != '0)
        else $error("erased byte not counted");

endmodule

bind comma_sync_soft_8b10b_decoder_core cssd_checker u_cssd_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .ev_valid (events.valid),
    .ev_ready (events.ready),
    .ev_kind  (events.event_kind),
    .ev_byte  (events.data_byte),
    .ev_erased(events.erased),
    .ev_dist  (events.distance),
    .ev_idx   (events.byte_index),
    .ev_count (events.erasure_count),
    .ev_last  (events.last_of_frame)
);

// ----- sim/testbench.sv -----
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the 8b10b comma sync decoder core. A queue of bits
// feeds a clocked driver; a clocked monitor checks every event against a
// behavioral predictor of comma hunt, word framing and nearest code word
// search, under several idle and stall mixes and register settings.
// ----------------------------------------------------------------------------
module testbench;

    typedef struct packed {
        logic                        kind;
        logic [cssd_pkg::BYTE_W-1:0] data;
        logic                        erased;
        logic [cssd_pkg::DIST_W-1:0] hdist;
        logic [cssd_pkg::BYTE_W-1:0] idx;
        logic [cssd_pkg::BYTE_W-1:0] ecount;
        logic                        last;
    } evt_t;

    localparam logic [5:0] SIX_TAB [32] = '{
        6'h27, 6'h1D, 6'h2D, 6'h31, 6'h35, 6'h29, 6'h19, 6'h38,
        6'h39, 6'h25, 6'h15, 6'h34, 6'h0D, 6'h2C, 6'h1C, 6'h17,
        6'h1B, 6'h23, 6'h13, 6'h32, 6'h0B, 6'h2A, 6'h1A, 6'h3A,
        6'h33, 6'h26, 6'h16, 6'h36, 6'h0E, 6'h2E, 6'h1E, 6'h2B
    };
    localparam logic [3:0] FOUR_TAB [8] = '{
        4'hB, 4'h9, 4'h5, 4'hC, 4'hD, 4'hA, 4'h6, 4'hE
    };
    localparam int DRAIN_CYCLES = 600;
    localparam int MAX_FRAME_TB = 255;

    logic clk;
    logic rst_n;

    cssd_cfg_if cfg_ch ();
    cssd_bit_if bit_ch ();
    cssd_evt_if evt_ch ();

    comma_sync_soft_8b10b_decoder_core u_top (
        .clk    (clk),
        .rst_n  (rst_n),
        .cfg    (cfg_ch),
        .bits   (bit_ch),
        .events (evt_ch)
    );

    logic [cssd_pkg::WORD_W-1:0] cw_tab [2][256];

    logic [cssd_pkg::WORD_W-1:0] m_comma;
    logic [cssd_pkg::BYTE_W-1:0] m_flen;
    logic [cssd_pkg::WORD_W-1:0] m_hunt;
    logic                        m_decoding;
    logic [3:0]                  m_phase;
    logic [cssd_pkg::WORD_W-1:0] m_word;
    logic [cssd_pkg::BYTE_W-1:0] m_count;
    logic [cssd_pkg::BYTE_W-1:0] m_erasures;

    logic bit_q [$];
    evt_t event_q [$];
    int   errors = 0;
    int   src_idle_pct = 0;
    int   snk_stall_pct = 0;
    int   hold_trig = 0;
    int   hold_seen = 0;
    int   hold_cnt = 0;
    logic bit_taken = 1'b0;

    always
    begin
        clk = 1'b1;
        #2;
        clk = 1'b0;
        #2;
    end

    function automatic int pop10(input logic [cssd_pkg::WORD_W-1:0] v);
        int n;
        n = 0;
        for (int i = 0; i < cssd_pkg::WORD_W; i++)
        begin
            n += v[i];
        end
        return n;
    endfunction

    function automatic logic [cssd_pkg::WORD_W-1:0] encode_byte(input logic [7:0] b,
                                                                input logic rdp);
        logic [4:0] x;
        logic [2:0] y;
        logic [5:0] six;
        logic [3:0] four;
        logic       unbal;
        logic       rd;
        logic       alt;
        x     = b[4:0];
        y     = b[7:5];
        six   = SIX_TAB[x];
        unbal = pop10({4'd0, six}) != 3;
        rd    = rdp;
        if (rd && (unbal || x == 5'd7))
        begin
            six = ~six;
        end
        if (unbal)
        begin
            rd = ~rd;
        end
        if (y == 3'd7)
        begin
            alt = (!rd && (x == 5'd17 || x == 5'd18 || x == 5'd20)) ||
                  (rd && (x == 5'd11 || x == 5'd13 || x == 5'd14));
            four = alt ? 4'h7 : 4'hE;
            if (rd)
            begin
                four = ~four;
            end
        end
        else
        begin
            four = FOUR_TAB[y];
            if (rd && (pop10({6'd0, four}) != 2 || y == 3'd3))
            begin
                four = ~four;
            end
        end
        return {six, four};
    endfunction

    task automatic decode_bit(input logic b);
        evt_t e;
        int   best;
        int   best_d;
        int   d;
        int   words;
        if (!m_decoding)
        begin
            m_hunt = {m_hunt[cssd_pkg::WORD_W-2:0], b};
            if (m_hunt == m_comma || m_hunt == ~m_comma)
            begin
                m_decoding = 1'b1;
                m_phase    = '0;
                m_word     = '0;
                m_count    = '0;
                m_erasures = '0;
                e = '0;
                e.kind = cssd_pkg::KIND_COMMA;
                event_q.push_back(e);
            end
            return;
        end
        m_word = {m_word[cssd_pkg::WORD_W-2:0], b};
        if (m_phase < cssd_pkg::LAST_PHASE)
        begin
            m_phase++;
            return;
        end
        m_phase = '0;
        best   = 0;
        best_d = cssd_pkg::NO_DIST;
        for (int p = 0; p < 2 && best_d > 0; p++)
        begin
            for (int i = 0; i < 256 && best_d > 0; i++)
            begin
                d = pop10(m_word ^ cw_tab[p][i]);
                if (d < best_d)
                begin
                    best_d = d;
                    best   = i;
                end
            end
        end
        if (best_d != 0 && m_erasures != 8'd255)
        begin
            m_erasures++;
        end
        words = (m_flen == 0) ? 1 : m_flen;
        if (words > MAX_FRAME_TB)
        begin
            words = MAX_FRAME_TB;
        end
        e.kind   = cssd_pkg::KIND_BYTE;
        e.data   = best[7:0];
        e.erased = best_d != 0;
        e.hdist  = best_d[3:0];
        e.idx    = m_count;
        e.ecount = m_erasures;
        e.last   = (int'(m_count) + 1 >= words);
        if (e.last)
        begin
            m_decoding = 1'b0;
            m_count    = '0;
        end
        else
        begin
            m_count++;
        end
        event_q.push_back(e);
    endtask

    // bit driver
    always @(posedge clk)
    begin
        bit_taken <= rst_n && bit_ch.valid && bit_ch.ready;
        if (rst_n && bit_ch.valid && bit_ch.ready)
        begin
            decode_bit(bit_ch.in_bit);
            void'(bit_q.pop_front());
        end
    end

    always @(negedge clk)
    begin
        if (!(bit_ch.valid && !bit_taken))
        begin
            if (bit_q.size() != 0 && $urandom_range(99) >= src_idle_pct)
            begin
                bit_ch.valid  <= 1'b1;
                bit_ch.in_bit <= bit_q[0];
            end
            else
            begin
                bit_ch.valid  <= 1'b0;
                bit_ch.in_bit <= 1'($urandom_range(1));
            end
        end
    end

    // long receiver hold-off
    always @(negedge clk)
    begin
        if (hold_cnt != 0)
        begin
            hold_cnt <= hold_cnt - 1;
        end
        else if (hold_trig != hold_seen)
        begin
            hold_cnt  <= 400;
            hold_seen <= hold_trig;
        end
    end

    always @(negedge clk)
    begin
        evt_ch.ready <= (hold_cnt == 0) && ($urandom_range(99) >= snk_stall_pct);
    end

    // event monitor
    always @(posedge clk)
    begin
        evt_t got;
        evt_t want;
        if (rst_n && evt_ch.valid && evt_ch.ready)
        begin
            got.kind   = evt_ch.event_kind;
            got.data   = evt_ch.data_byte;
            got.erased = evt_ch.erased;
            got.hdist  = evt_ch.distance;
            got.idx    = evt_ch.byte_index;
            got.ecount = evt_ch.erasure_count;
            got.last   = evt_ch.last_of_frame;
            if (event_q.size() == 0)
            begin
                $display("%0t: unexpected event, actual %p", $realtime, got);
                errors++;
            end
            else
            begin
                want = event_q.pop_front();
                if (got !== want)
                begin
                    $display("%0t: event mismatch, expected %p, actual %p",
                             $realtime, want, got);
                    errors++;
                end
            end
        end
    end

    task automatic write_reg(input logic [cssd_pkg::CFG_IDX_W-1:0] idx,
                             input logic [cssd_pkg::CFG_DATA_W-1:0] val);
        @(negedge clk);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= idx;
        cfg_ch.data  <= val;
        @(posedge clk);
        while (!cfg_ch.ready)
        begin
            @(posedge clk);
        end
        if (idx == cssd_pkg::REG_COMMA)
        begin
            m_comma = val[cssd_pkg::WORD_W-1:0];
        end
        else
        begin
            m_flen = val[cssd_pkg::BYTE_W-1:0];
        end
        @(negedge clk);
        cfg_ch.valid <= 1'b0;
    endtask

    task automatic push_word(input logic [cssd_pkg::WORD_W-1:0] w);
        for (int i = cssd_pkg::WORD_W - 1; i >= 0; i--)
        begin
            bit_q.push_back(w[i]);
        end
    endtask

    task automatic drain();
        while (bit_q.size() != 0 || event_q.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic random_frames(input int nbits, input int max_words);
        int  target;
        int  nw;
        logic [cssd_pkg::WORD_W-1:0] w;
        target = bit_q.size() + nbits;
        while (bit_q.size() < target)
        begin
            repeat ($urandom_range(12)) bit_q.push_back(1'($urandom_range(1)));
            push_word($urandom_range(1) ? m_comma : ~m_comma);
            nw = $urandom_range(max_words, 1);
            if ($urandom_range(9) == 0)
            begin
                nw = nw / 2;
            end
            for (int k = 0; k < nw; k++)
            begin
                w = cw_tab[$urandom_range(1)][$urandom_range(255)];
                case ($urandom_range(5))
                    0: w = 10'($urandom_range(1023));
                    1, 2: w ^= (10'd1 << $urandom_range(9));
                    3: w ^= (10'd1 << $urandom_range(9)) | (10'd1 << $urandom_range(9));
                    default: ;
                endcase
                push_word(w);
            end
        end
    endtask

    initial
    begin
        int pcts [4][2];
        logic [cssd_pkg::WORD_W-1:0] commas [4];
        logic [cssd_pkg::BYTE_W-1:0] flens [4];
        pcts   = '{'{0, 0}, '{55, 0}, '{0, 55}, '{15, 15}};
        commas = '{10'h3FF, 10'h17C, 10'h000, cssd_pkg::COMMA_RESET};
        flens  = '{8'd1, 8'd6, 8'd255, 8'd4};
        for (int p = 0; p < 2; p++)
        begin
            for (int i = 0; i < 256; i++)
            begin
                cw_tab[p][i] = encode_byte(i[7:0], p[0]);
            end
        end
        m_comma    = cssd_pkg::COMMA_RESET;
        m_flen     = cssd_pkg::FRAME_RESET;
        m_hunt     = '0;
        m_decoding = 1'b0;
        m_phase    = '0;
        m_word     = '0;
        m_count    = '0;
        m_erasures = '0;
        rst_n        = 1'b0;
        cfg_ch.valid = 1'b0;
        cfg_ch.index = cssd_pkg::REG_COMMA;
        cfg_ch.data  = '0;
        bit_ch.valid = 1'b0;
        bit_ch.in_bit = 1'b0;
        evt_ch.ready = 1'b0;
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // directed: reset comma, then exact, worst and complement cases
        write_reg(cssd_pkg::REG_FRAME, 10'd3);
        push_word(cssd_pkg::COMMA_RESET);
        push_word(cw_tab[0][0]);
        push_word(cw_tab[1][255]);
        push_word(10'h3FF);
        push_word(~cssd_pkg::COMMA_RESET);
        push_word(10'h000);
        push_word(cw_tab[1][8'hE0] ^ 10'h201);
        push_word(10'h2AA);
        drain();
        write_reg(cssd_pkg::REG_FRAME, 10'd0);
        push_word(~cssd_pkg::COMMA_RESET);
        push_word(10'h155);
        drain();

        for (int ph = 0; ph < 4; ph++)
        begin
            write_reg(cssd_pkg::REG_COMMA, commas[ph]);
            write_reg(cssd_pkg::REG_FRAME, {2'b00, flens[ph]});
            src_idle_pct  = pcts[ph][0];
            snk_stall_pct = pcts[ph][1];
            if (ph == 0)
            begin
                @(posedge clk);
                hold_trig++;
            end
            random_frames(210, (flens[ph] == 8'd255) ? 20 : 8);
            drain();
        end
        // frame length lowered while a long frame is still open
        write_reg(cssd_pkg::REG_FRAME, 10'd2);
        random_frames(60, 3);
        drain();

        if (errors == 0)
        begin
            $display("All tests passed");
        end
        else
        begin
            $display("Some tests failed");
        end
        $finish;
    end

    initial
    begin
        #4000000;
        $display("Some tests failed");
        $finish;
    end

endmodule
